/* rtl/sptd_pkg.sv */
`timescale 1ns / 1ps

package sptd_pkg;

  // fixed field widths of the result stream
  localparam int unsigned DIST_W = 17;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned TICK_W = 32;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELD_W = DIST_W + SUM_W + TICK_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/sptd_front.sv */
`timescale 1ns / 1ps

module sptd_front #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       event_a_i,
  input  logic                       event_b_i,
  input  sptd_pkg::q_stat_t          q_stat_i,
  output logic                       push_o,
  output logic [2*COUNT_WIDTH+1:0]   entry_o   // {numerator, denominator}
);

  localparam int unsigned CW = COUNT_WIDTH;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'b00,
    KIND_B_ONLY = 2'b01,
    KIND_A_ONLY = 2'b10,
    KIND_BOTH   = 2'b11
  } kind_e;

  logic [CW-1:0] since_a_q, since_a_d, since_b_q, since_b_d;
  logic [CW-1:0] gap_ab_q, gap_ab_d, gap_ba_q, gap_ba_d;
  logic          seen_a_q, seen_a_d, seen_b_q, seen_b_d;
  logic [CW-1:0] inc_a, inc_b;
  logic [CW:0]   num, den;
  kind_e         kind;

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;
  assign kind       = kind_e'({event_a_i, event_b_i});

  always_comb begin
    inc_a = (since_a_q == '1) ? since_a_q : since_a_q + CW'(1);
    inc_b = (since_b_q == '1) ? since_b_q : since_b_q + CW'(1);
    since_a_d = event_a_i ? '0 : inc_a;
    since_b_d = event_b_i ? '0 : inc_b;
    gap_ab_d  = gap_ab_q;
    gap_ba_d  = gap_ba_q;
    seen_a_d  = seen_a_q || event_a_i;
    seen_b_d  = seen_b_q || event_b_i;
    den       = '0;
    case (kind)
      KIND_A_ONLY: begin
        if (gap_ba_q > since_b_d || !seen_a_q) begin
          gap_ba_d = since_b_d;
        end
        gap_ab_d = since_b_d;
        den      = {1'b0, since_b_d};
      end
      KIND_B_ONLY: begin
        if (gap_ab_q > since_a_d || !seen_b_q) begin
          gap_ab_d = since_a_d;
        end
        gap_ba_d = since_a_d;
        den      = {1'b0, since_a_d};
      end
      KIND_BOTH: begin
        // zero denominator marks a zero result downstream
        gap_ab_d = '0;
        gap_ba_d = '0;
        den      = '0;
      end
      default: begin
        den = {1'b0, since_a_d} + {1'b0, since_b_d};
      end
    endcase
    num = {1'b0, gap_ba_d} + {1'b0, gap_ab_d};
  end

  assign entry_o = {num, den};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_a_q <= '0;
      since_b_q <= '0;
      gap_ab_q  <= '0;
      gap_ba_q  <= '0;
      seen_a_q  <= 1'b0;
      seen_b_q  <= 1'b0;
    end else if (push_o) begin
      since_a_q <= since_a_d;
      since_b_q <= since_b_d;
      gap_ab_q  <= gap_ab_d;
      gap_ba_q  <= gap_ba_d;
      seen_a_q  <= seen_a_d;
      seen_b_q  <= seen_b_d;
    end
  end

endmodule

/* rtl/sptd_queue.sv */
`timescale 1ns / 1ps

module sptd_queue #(
  parameter int unsigned WIDTH = 66
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     data_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     data_o,
  output sptd_pkg::q_stat_t    stat_o
);

  logic [WIDTH-1:0]              mem_q [sptd_pkg::QUEUE_DEPTH];
  logic [sptd_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
  logic [sptd_pkg::QCNT_W-1:0]   cnt_q;

  assign stat_o.full  = (cnt_q == sptd_pkg::QCNT_W'(sptd_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + sptd_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + sptd_pkg::QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + sptd_pkg::QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - sptd_pkg::QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/sptd_back.sv */
`timescale 1ns / 1ps

module sptd_back #(
  parameter int unsigned COUNT_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sptd_pkg::q_stat_t                  q_stat_i,
  output logic                               pop_o,
  input  logic [2*COUNT_WIDTH+1:0]           entry_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sptd_pkg::DIST_W-1:0]        distance_o,
  output logic [sptd_pkg::SUM_W-1:0]         running_sum_o,
  output logic [sptd_pkg::TICK_W-1:0]        tick_count_o
);

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned RW    = CW + 3;           // remainder and divisor
  localparam int unsigned QW    = FB + 1;           // quotient incl. 1.0
  localparam int unsigned CNT_W = $clog2(FB + 1);
  localparam int unsigned SW    = sptd_pkg::SUM_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC
  } state_e;

  state_e                    state_q;
  logic                      acc_en_q;
  logic                      out_valid_q;
  logic [sptd_pkg::DIST_W-1:0] dist_q;
  logic [SW-1:0]             sum_q;
  logic [sptd_pkg::TICK_W-1:0] tick_q;

  logic [RW-1:0]    rem_q, div_q;
  logic [QW-1:0]    quo_q;
  logic [CNT_W-1:0] cnt_q;

  logic [CW:0]      num_in, den_in;
  logic [RW-1:0]    div_in, rem_sh;
  logic             den_zero, ratio_full, sub_ok, out_free;
  logic [SW:0]      sum_ext;
  logic [QW+sptd_pkg::DIST_W-1:0] dist_ext;

  assign num_in     = entry_i[2*CW+1:CW+1];
  assign den_in     = entry_i[CW:0];
  assign div_in     = RW'({den_in, 1'b0});
  assign den_zero   = (den_in == '0);
  assign ratio_full = (RW'(num_in) >= div_in);
  assign pop_o      = (state_q == ST_IDLE) && !q_stat_i.empty;

  assign rem_sh = {rem_q[RW-2:0], 1'b0};
  assign sub_ok = (rem_sh >= div_q);

  assign out_free = !out_valid_q || out_ready_i;
  assign sum_ext  = {1'b0, sum_q} + (SW+1)'(quo_q);
  assign dist_ext = {{sptd_pkg::DIST_W{1'b0}}, quo_q};

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        rem_q <= RW'(num_in);
        div_q <= div_in;
        cnt_q <= CNT_W'(FB);
        if (!den_zero && ratio_full) begin
          quo_q <= QW'(1) << FB;
        end else begin
          quo_q <= '0;
        end
      end
      ST_DIV: begin
        rem_q <= sub_ok ? rem_sh - div_q : rem_sh;
        quo_q <= {quo_q[QW-2:0], sub_ok};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_en_q    <= 1'b1;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
      sum_q       <= '0;
      tick_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        acc_en_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            state_q <= (den_zero || ratio_full) ? ST_ACC : ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          // wait for the output register to drain before committing
          if (out_free) begin
            if (acc_en_q) begin
              sum_q <= sum_ext[SW] ? '1 : sum_ext[SW-1:0];
            end
            if (tick_q != '1) begin
              tick_q <= tick_q + sptd_pkg::TICK_W'(1);
            end
            dist_q      <= dist_ext[sptd_pkg::DIST_W-1:0];
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_o    = dist_q;
  assign running_sum_o = sum_q;
  assign tick_count_o  = tick_q;

endmodule

/* rtl/spike_train_distance.sv */
`timescale 1ns / 1ps
// Channel    Dir  Handshake                    Payload
// s_axis     in   s_axis_tvalid/s_axis_tready  tdata[0] event_a, [1] event_b
// m_axis     out  m_axis_tvalid/m_axis_tready  tdata distance, running_sum, tick_count
// cfg        in   cfg_valid_i/cfg_ready_o      cfg_data_i accumulate_enable
//
// A request passes through the back end as a pop, the restoring divider (one quotient
// bit per cycle), then accumulation once the output register is free; a tick that yields
// zero or a saturated ratio skips the divider. The divider sets the sustained rate.
// Front state updates in the cycle of acceptance; a two-entry queue lets it run ahead.
// Reset is asynchronous, active low; accumulate_enable resets to 1.
// A stalled result holds in the output register; the front keeps accepting until
// the queue fills.

module spike_train_distance #(
  parameter int unsigned COUNT_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sptd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // event_a, event_b
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sptd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // distance, running_sum,
                                                              // tick_count, zero pad
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_data_i      // accumulate_enable
);

  localparam int unsigned EW = 2 * COUNT_WIDTH + 2;

  sptd_pkg::q_stat_t              q_stat;
  logic                           push, pop;
  logic [EW-1:0]                  entry_in, entry_out;
  logic [sptd_pkg::DIST_W-1:0]    distance;
  logic [sptd_pkg::SUM_W-1:0]     running_sum;
  logic [sptd_pkg::TICK_W-1:0]    tick_count;

  assign cfg_ready_o = 1'b1;

  sptd_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .event_a_i  (s_axis_tdata[0]),
    .event_b_i  (s_axis_tdata[1]),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (entry_in)
  );

  sptd_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (entry_in),
    .pop_i  (pop),
    .data_o (entry_out),
    .stat_o (q_stat)
  );

  sptd_back #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .entry_i       (entry_out),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .distance_o    (distance),
    .running_sum_o (running_sum),
    .tick_count_o  (tick_count)
  );

  assign m_axis_tdata = {{(sptd_pkg::OUT_TDATA_W - sptd_pkg::OUT_FIELD_W){1'b0}},
                         tick_count, running_sum, distance};

endmodule

/* tb/tb_spike_train_distance.sv */
`timescale 1ns / 1ps

module tb_spike_train_distance;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam logic [63:0] CNT_MAX = (64'd1 << CNT_W) - 64'd1;
  localparam logic [63:0] SUM_MAX = (64'd1 << sptd_pkg::SUM_W) - 64'd1;
  localparam logic [63:0] TICKMAX = (64'd1 << sptd_pkg::TICK_W) - 64'd1;
  localparam logic [63:0] ONE_FX  = 64'd1 << FRAC_W;

  typedef struct packed {
    logic [sptd_pkg::DIST_W-1:0] distance;
    logic [sptd_pkg::SUM_W-1:0]  running_sum;
    logic [sptd_pkg::TICK_W-1:0] tick_count;
  } dist_result_t;

  class distance_scoreboard;
    logic [63:0]  since_a, since_b, gap_ab, gap_ba, sum_acc, count_acc;
    bit           seen_a, seen_b;
    bit           acc_en;
    int unsigned  errors;
    dist_result_t pending_results[$];

    function new();
      since_a   = '0;
      since_b   = '0;
      gap_ab    = '0;
      gap_ba    = '0;
      sum_acc   = '0;
      count_acc = '0;
      seen_a    = 1'b0;
      seen_b    = 1'b0;
      acc_en    = 1'b1;
      errors    = 0;
    endfunction

    function logic [63:0] bump(logic [63:0] v);
      return (v >= CNT_MAX) ? CNT_MAX : v + 64'd1;
    endfunction

    // floor(num * 2^FRAC_W / (2 * den)), clipped to 1.0
    function logic [63:0] half_ratio(logic [63:0] num, logic [63:0] den);
      logic [63:0] dv, rem, q;
      if (den == 0) return '0;
      dv = den << 1;
      if (num >= dv) return ONE_FX;
      rem = num;
      q   = '0;
      for (int i = 0; i < FRAC_W; i++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= dv) begin
          rem  = rem - dv;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function void note_tick(bit ea, bit eb);
      logic [63:0]  dist_v;
      dist_result_t r;
      since_a = ea ? 64'd0 : bump(since_a);
      since_b = eb ? 64'd0 : bump(since_b);
      if (ea && !eb) begin
        if (gap_ba > since_b || !seen_a) gap_ba = since_b;
        gap_ab = since_b;
        dist_v = half_ratio(gap_ba + gap_ab, since_b);
      end else if (!ea && eb) begin
        if (gap_ab > since_a || !seen_b) gap_ab = since_a;
        gap_ba = since_a;
        dist_v = half_ratio(gap_ba + gap_ab, since_a);
      end else if (ea && eb) begin
        gap_ab = '0;
        gap_ba = '0;
        dist_v = '0;
      end else begin
        dist_v = half_ratio(gap_ba + gap_ab, since_a + since_b);
      end
      if (ea) seen_a = 1'b1;
      if (eb) seen_b = 1'b1;
      if (acc_en) begin
        if (dist_v > SUM_MAX - sum_acc) sum_acc = SUM_MAX;
        else sum_acc = sum_acc + dist_v;
      end
      if (count_acc < TICKMAX) count_acc = count_acc + 64'd1;
      r.distance    = dist_v[sptd_pkg::DIST_W-1:0];
      r.running_sum = sum_acc[sptd_pkg::SUM_W-1:0];
      r.tick_count  = count_acc[sptd_pkg::TICK_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [sptd_pkg::OUT_TDATA_W-1:0] data);
      dist_result_t exp_r;
      logic [sptd_pkg::DIST_W-1:0] d;
      logic [sptd_pkg::SUM_W-1:0]  s;
      logic [sptd_pkg::TICK_W-1:0] t;
      d = data[sptd_pkg::DIST_W-1:0];
      s = data[sptd_pkg::DIST_W +: sptd_pkg::SUM_W];
      t = data[sptd_pkg::DIST_W+sptd_pkg::SUM_W +: sptd_pkg::TICK_W];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result distance %0d sum %0d ticks %0d", $time, d, s, t);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (d !== exp_r.distance) begin
        $display("%0t: distance expected %0d actual %0d", $time, exp_r.distance, d);
        errors++;
      end
      if (s !== exp_r.running_sum) begin
        $display("%0t: running_sum expected %0d actual %0d", $time, exp_r.running_sum, s);
        errors++;
      end
      if (t !== exp_r.tick_count) begin
        $display("%0t: tick_count expected %0d actual %0d", $time, exp_r.tick_count, t);
        errors++;
      end
    endfunction
  endclass

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [sptd_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [sptd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             cfg_valid_i   = 1'b0;
  logic                             cfg_ready_o;
  logic                             cfg_data_i    = 1'b0;

  distance_scoreboard sb = new();
  bit          no_idle    = 1'b0;
  int unsigned stall_left = 0;
  bit [1:0]    opening[22] = '{2'b00, 2'b00, 2'b01, 2'b00, 2'b00, 2'b10, 2'b10, 2'b00,
                               2'b01, 2'b11, 2'b00, 2'b01, 2'b01, 2'b10, 2'b00, 2'b00,
                               2'b10, 2'b01, 2'b11, 2'b11, 2'b01, 2'b10};

  spike_train_distance #(
    .COUNT_WIDTH  (CNT_W),
    .FRACTION_BITS(FRAC_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // receiver back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(1, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic send_tick(input bit ea, input bit eb);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(sptd_pkg::IN_TDATA_W-2){1'b0}}, eb, ea};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_tick(ea, eb);
  endtask

  task automatic write_accumulate(input bit en);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.acc_en = en;
  endtask

  // spike trains with firing rates that change every few dozen ticks
  task automatic random_trains(input int unsigned n);
    int unsigned rate_a, rate_b;
    rate_a = 4;
    rate_b = 4;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        rate_a = 1 << $urandom_range(1, 4);
        rate_b = 1 << $urandom_range(1, 4);
      end
      send_tick($urandom_range(0, rate_a - 1) == 0, $urandom_range(0, rate_b - 1) == 0);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_accumulate(1'b1);
    // unseen trains, lone spikes, coincident spikes
    foreach (opening[i]) send_tick(opening[i][0], opening[i][1]);
    s_axis_tvalid <= 1'b0;

    write_accumulate(1'b0);
    random_trains(200);
    write_accumulate(1'b1);
    random_trains(250);
    write_accumulate(1'b0);
    random_trains(60);
    write_accumulate(1'b1);
    no_idle = 1'b1;
    random_trains(190);

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* spike_train_distance.f */
rtl/sptd_pkg.sv
rtl/sptd_front.sv
rtl/sptd_queue.sv
rtl/sptd_back.sv
rtl/spike_train_distance.sv
tb/tb_spike_train_distance.sv
